// ===== sv/spj_pkg.sv =====
// ----------------------------------------------------------------------------
// spj_pkg
// Shared types, operation codes and constants of the proximity join.
// ----------------------------------------------------------------------------
package spj_pkg;

  localparam int ROW_FW = 7;

  localparam logic signed [31:0] DEG_FULL = 32'sd377487360;
  localparam logic signed [31:0] DEG_HALF = 32'sd188743680;
  localparam logic signed [31:0] DEG_QTR  = 32'sd94371840;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [45:0] KM_SCALE = 46'd111111;
  localparam logic [45:0] KM_ROUND = 46'd2048000;
  localparam logic [45:0] KM_DIV   = 46'd4096000;

  localparam logic [4:0] MUL_LAST = 5'd17;
  localparam logic [4:0] SQ_LAST  = 5'd31;

  localparam logic [4:0] OP_NOP       = 5'd0;
  localparam logic [4:0] OP_CLEAR     = 5'd1;
  localparam logic [4:0] OP_LOAD      = 5'd2;
  localparam logic [4:0] OP_READ      = 5'd3;
  localparam logic [4:0] OP_SC_INIT   = 5'd4;
  localparam logic [4:0] OP_SC_STEP   = 5'd5;
  localparam logic [4:0] OP_SC_STORE  = 5'd6;
  localparam logic [4:0] OP_MUL       = 5'd7;
  localparam logic [4:0] OP_SQ_INIT   = 5'd8;
  localparam logic [4:0] OP_SQ_STEP   = 5'd9;
  localparam logic [4:0] OP_VEC_INIT  = 5'd10;
  localparam logic [4:0] OP_VEC_STEP  = 5'd11;
  localparam logic [4:0] OP_FINISH    = 5'd12;
  localparam logic [4:0] OP_SET_PEND  = 5'd13;
  localparam logic [4:0] OP_PUSH_MID  = 5'd14;
  localparam logic [4:0] OP_PUSH_LAST = 5'd15;
  localparam logic [4:0] OP_PUSH_FULL = 5'd16;

  localparam logic [1:0] SEL_ROW_LAT = 2'd0;
  localparam logic [1:0] SEL_NEW_LAT = 2'd1;
  localparam logic [1:0] SEL_LON     = 2'd2;

  typedef struct packed {
    logic [4:0]        op;
    logic [1:0]        sel;
    logic [4:0]        iter;
    logic [ROW_FW-1:0] row;
    logic              pend_v;
  } spj_cmd_t;

  typedef struct packed {
    logic [ROW_FW-1:0] cnt;
    logic              pair_ok;
    logic              hit;
    logic              out_free;
  } spj_sts_t;

  typedef struct packed {
    logic [7:0]         src;
    logic signed [31:0] day;
    logic signed [23:0] lat;
    logic signed [24:0] lon;
  } spj_row_t;

  function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
    logic signed [31:0] v;
    unique case (i)
      5'd0:  v = 32'sd47185920;
      5'd1:  v = 32'sd27855475;
      5'd2:  v = 32'sd14718068;
      5'd3:  v = 32'sd7471121;
      5'd4:  v = 32'sd3750058;
      5'd5:  v = 32'sd1876857;
      5'd6:  v = 32'sd938658;
      5'd7:  v = 32'sd469357;
      5'd8:  v = 32'sd234682;
      5'd9:  v = 32'sd117342;
      5'd10: v = 32'sd58671;
      5'd11: v = 32'sd29335;
      5'd12: v = 32'sd14668;
      5'd13: v = 32'sd7334;
      5'd14: v = 32'sd3667;
      5'd15: v = 32'sd1833;
      5'd16: v = 32'sd917;
      5'd17: v = 32'sd458;
      5'd18: v = 32'sd229;
      5'd19: v = 32'sd115;
      5'd20: v = 32'sd57;
      5'd21: v = 32'sd29;
      5'd22: v = 32'sd14;
      5'd23: v = 32'sd7;
      5'd24: v = 32'sd4;
      5'd25: v = 32'sd2;
      5'd26: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/spj_ctrl.sv =====
// ----------------------------------------------------------------------------
// spj_ctrl
// Sequencer of the proximity join: walks the stored rows and steps the datapath.
// ----------------------------------------------------------------------------
module spj_ctrl #(
  parameter int MAX_ROWS     = 64,
  parameter int CORDIC_STEPS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_clear,
  input  spj_pkg::spj_sts_t sts,
  output spj_pkg::spj_cmd_t cmd
);
  import spj_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOOP = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_SCI  = 4'd3;
  localparam logic [3:0] S_SCIT = 4'd4;
  localparam logic [3:0] S_SCST = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_SQI  = 4'd7;
  localparam logic [3:0] S_SQ   = 4'd8;
  localparam logic [3:0] S_VI   = 4'd9;
  localparam logic [3:0] S_VIT  = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;
  localparam logic [3:0] S_CMP  = 4'd12;
  localparam logic [3:0] S_HOLD = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;
  localparam logic [3:0] S_FULL = 4'd15;

  localparam logic [4:0] STEP_LAST = 5'(CORDIC_STEPS - 1);
  localparam logic [ROW_FW-1:0] ROWS_MAX = ROW_FW'(MAX_ROWS);

  logic [3:0]        state_r, state_nxt;
  logic [ROW_FW-1:0] row_r, row_nxt;
  logic [4:0]        iter_r, iter_nxt;
  logic [1:0]        sel_r, sel_nxt;
  logic              pend_v_r, pend_v_nxt;

  always_comb begin
    state_nxt  = state_r;
    row_nxt    = row_r;
    iter_nxt   = iter_r;
    sel_nxt    = sel_r;
    pend_v_nxt = pend_v_r;
    in_tready  = 1'b0;
    cmd.op     = OP_NOP;
    cmd.sel    = sel_r;
    cmd.iter   = iter_r;
    cmd.row    = row_r;
    cmd.pend_v = pend_v_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_clear) begin
            cmd.op = OP_CLEAR;
          end else if (sts.cnt == ROWS_MAX) begin
            state_nxt = S_FULL;
          end else begin
            cmd.op     = OP_LOAD;
            row_nxt    = '0;
            pend_v_nxt = 1'b0;
            state_nxt  = S_LOOP;
          end
        end
      end
      S_LOOP: begin
        if (row_r == sts.cnt) begin
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_READ;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.pair_ok) begin
          sel_nxt   = SEL_ROW_LAT;
          state_nxt = S_SCI;
        end else begin
          row_nxt   = row_r + 1'b1;
          state_nxt = S_LOOP;
        end
      end
      S_SCI: begin
        cmd.op    = OP_SC_INIT;
        iter_nxt  = '0;
        state_nxt = S_SCIT;
      end
      S_SCIT: begin
        cmd.op = OP_SC_STEP;
        iter_nxt = iter_r + 1'b1;
        if (iter_r == STEP_LAST) begin
          state_nxt = S_SCST;
        end
      end
      S_SCST: begin
        cmd.op = OP_SC_STORE;
        if (sel_r == SEL_LON) begin
          iter_nxt  = '0;
          state_nxt = S_MUL;
        end else begin
          sel_nxt   = sel_r + 1'b1;
          state_nxt = S_SCI;
        end
      end
      S_MUL: begin
        cmd.op   = OP_MUL;
        iter_nxt = iter_r + 1'b1;
        if (iter_r == MUL_LAST) begin
          state_nxt = S_SQI;
        end
      end
      S_SQI: begin
        cmd.op    = OP_SQ_INIT;
        iter_nxt  = '0;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.op   = OP_SQ_STEP;
        iter_nxt = iter_r + 1'b1;
        if (iter_r == SQ_LAST) begin
          state_nxt = S_VI;
        end
      end
      S_VI: begin
        cmd.op    = OP_VEC_INIT;
        iter_nxt  = '0;
        state_nxt = S_VIT;
      end
      S_VIT: begin
        cmd.op   = OP_VEC_STEP;
        iter_nxt = iter_r + 1'b1;
        if (iter_r == STEP_LAST) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.op    = OP_FINISH;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (sts.hit && pend_v_r) begin
          state_nxt = S_HOLD;
        end else begin
          if (sts.hit) begin
            cmd.op     = OP_SET_PEND;
            pend_v_nxt = 1'b1;
          end
          row_nxt   = row_r + 1'b1;
          state_nxt = S_LOOP;
        end
      end
      S_HOLD: begin
        if (sts.out_free) begin
          cmd.op    = OP_PUSH_MID;
          row_nxt   = row_r + 1'b1;
          state_nxt = S_LOOP;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.op    = OP_PUSH_LAST;
          state_nxt = S_IDLE;
        end
      end
      S_FULL: begin
        if (sts.out_free) begin
          cmd.op    = OP_PUSH_FULL;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      row_r    <= '0;
      iter_r   <= '0;
      sel_r    <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      row_r    <= row_nxt;
      iter_r   <= iter_nxt;
      sel_r    <= sel_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

`ifndef SYNTHESIS
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= ROWS_MAX) else $error("row walk ran past the store");
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_tready) else $error("item taken while busy");
  a_hold_has_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HOLD |-> pend_v_r) else $error("hold without pending pair");
`endif

endmodule

// ===== sv/spj_dp.sv =====
// ----------------------------------------------------------------------------
// spj_dp
// Datapath of the proximity join: row store, CORDIC, multiplier, root, output.
// ----------------------------------------------------------------------------
module spj_dp #(
  parameter int MAX_ROWS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [22:0]       cfg_wdata,
  input  logic [88:0]       in_row,
  input  spj_pkg::spj_cmd_t cmd,
  output spj_pkg::spj_sts_t sts,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,
  output logic [1:0]        out_tuser,
  output logic              out_tlast
);
  import spj_pkg::*;

  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNT_W = $clog2(MAX_ROWS + 1);
  localparam logic [1:0] REG_TIME_WINDOW = 2'd0;
  localparam logic [1:0] REG_DIST_LIMIT  = 2'd1;

  logic [15:0] tw_r;
  logic [22:0] dl_r;
  logic [45:0] thr_r;
  logic [CNT_W-1:0] cnt_r;

  spj_row_t mem [MAX_ROWS];
  spj_row_t rd_r, new_r, in_rec;

  logic signed [31:0] ct_r;
  logic signed [33:0] cx_r, cy_r;
  logic               flip_r;
  logic signed [31:0] ca_r, sa_r, cb_r, sb_r, cl_r, sl_r;
  logic signed [67:0] prod_r;
  logic signed [31:0] p_r, t1_r, t2_r, t3_r, t4_r, t5_r, t6_r;
  logic [63:0] pp_r, qq_r, n_r, r_r, bit_r;
  logic signed [33:0] vx_r, vy_r;
  logic signed [31:0] vz_r;
  logic [45:0] dprod_r;
  logic [ROW_FW-1:0] pend_r;
  logic        ov_r, olast_r;
  logic [1:0]  ouser_r;
  logic [20:0] odata_r;

  logic signed [32:0] day_diff;
  logic [32:0]        day_abs;
  logic signed [25:0] lon_diff;
  logic signed [31:0] ang, a0, a1, a2;
  logic               fold;
  logic signed [31:0] atan_v, qres;
  logic signed [33:0] sx, sy, vsx, vsy, opa, opb, pe, ap, aq;
  logic signed [32:0] q_v, xv;
  logic signed [33:0] cx_o, cy_o;
  logic [63:0]        rb;
  logic signed [31:0] th32;
  logic [27:0]        th;
  logic [3:0]         mk;
  logic [ROW_FW-1:0]  new_row;

  assign in_rec   = spj_row_t'(in_row);
  assign day_diff = {rd_r.day[31], rd_r.day} - {new_r.day[31], new_r.day};
  assign day_abs  = day_diff[32] ? 33'(-day_diff) : 33'(day_diff);
  assign lon_diff = {rd_r.lon[24], rd_r.lon} - {new_r.lon[24], new_r.lon};
  assign new_row  = ROW_FW'(cnt_r) + 1'b1;

  always_comb begin
    unique case (cmd.sel)
      SEL_ROW_LAT: ang = {{4{rd_r.lat[23]}}, rd_r.lat, 4'b0};
      SEL_NEW_LAT: ang = {{4{new_r.lat[23]}}, new_r.lat, 4'b0};
      default:     ang = {{2{lon_diff[25]}}, lon_diff, 4'b0};
    endcase
    if (ang >= DEG_FULL) begin
      a0 = ang - DEG_FULL;
    end else if (ang <= -DEG_FULL) begin
      a0 = ang + DEG_FULL;
    end else begin
      a0 = ang;
    end
    if (a0 > DEG_HALF) begin
      a1 = a0 - DEG_FULL;
    end else if (a0 < -DEG_HALF) begin
      a1 = a0 + DEG_FULL;
    end else begin
      a1 = a0;
    end
    fold = 1'b1;
    if (a1 > DEG_QTR) begin
      a2 = a1 - DEG_HALF;
    end else if (a1 < -DEG_QTR) begin
      a2 = a1 + DEG_HALF;
    end else begin
      a2   = a1;
      fold = 1'b0;
    end
  end

  assign atan_v = atan_deg(cmd.iter);
  assign sx  = cx_r >>> cmd.iter;
  assign sy  = cy_r >>> cmd.iter;
  assign vsx = vx_r >>> cmd.iter;
  assign vsy = vy_r >>> cmd.iter;
  assign cx_o = flip_r ? -cx_r : cx_r;
  assign cy_o = flip_r ? -cy_r : cy_r;

  assign q_v  = {t1_r[31], t1_r} - {t3_r[31], t3_r};
  assign xv   = {t4_r[31], t4_r} + {t6_r[31], t6_r};
  assign pe   = {{2{p_r[31]}}, p_r};
  assign ap   = pe[33] ? -pe : pe;
  assign aq   = q_v[32] ? -{q_v[32], q_v} : {q_v[32], q_v};
  assign qres = prod_r[61:30];
  assign mk   = cmd.iter[4:1];

  always_comb begin
    unique case (mk)
      4'd0: begin opa = 34'(cb_r); opb = 34'(sl_r); end
      4'd1: begin opa = 34'(ca_r); opb = 34'(sb_r); end
      4'd2: begin opa = 34'(sa_r); opb = 34'(cb_r); end
      4'd3: begin opa = 34'(t2_r); opb = 34'(cl_r); end
      4'd4: begin opa = 34'(sa_r); opb = 34'(sb_r); end
      4'd5: begin opa = 34'(ca_r); opb = 34'(cb_r); end
      4'd6: begin opa = 34'(t5_r); opb = 34'(cl_r); end
      4'd7: begin opa = ap;        opb = ap;        end
      4'd8: begin opa = aq;        opb = aq;        end
      default: begin opa = '0;     opb = '0;        end
    endcase
  end

  assign rb = r_r + bit_r;

  always_comb begin
    if (vz_r < 0) begin
      th32 = '0;
    end else if (vz_r > DEG_HALF) begin
      th32 = DEG_HALF;
    end else begin
      th32 = vz_r;
    end
    th = th32[27:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      mem[cnt_r[ROW_W-1:0]] <= in_rec;
    end
    if (cmd.op == OP_READ) begin
      rd_r <= mem[cmd.row[ROW_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_r  <= '0;
      dl_r  <= '0;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      if (cfg_we && cfg_addr == REG_TIME_WINDOW) begin
        tw_r <= cfg_wdata[15:0];
      end
      if (cfg_we && cfg_addr == REG_DIST_LIMIT) begin
        dl_r <= cfg_wdata;
      end
      if (cmd.op == OP_CLEAR) begin
        cnt_r <= '0;
      end else if (cmd.op == OP_PUSH_LAST) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.op == OP_PUSH_MID || cmd.op == OP_PUSH_LAST || cmd.op == OP_PUSH_FULL) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    thr_r <= (46'(dl_r) + 46'd1) * KM_DIV;
    unique case (cmd.op)
      OP_LOAD: new_r <= in_rec;
      OP_SC_INIT: begin
        ct_r   <= a2;
        cx_r   <= CORDIC_GAIN;
        cy_r   <= '0;
        flip_r <= fold;
      end
      OP_SC_STEP: begin
        if (ct_r >= 0) begin
          cx_r <= cx_r - sy;
          cy_r <= cy_r + sx;
          ct_r <= ct_r - atan_v;
        end else begin
          cx_r <= cx_r + sy;
          cy_r <= cy_r - sx;
          ct_r <= ct_r + atan_v;
        end
      end
      OP_SC_STORE: begin
        unique case (cmd.sel)
          SEL_ROW_LAT: begin ca_r <= cx_o[31:0]; sa_r <= cy_o[31:0]; end
          SEL_NEW_LAT: begin cb_r <= cx_o[31:0]; sb_r <= cy_o[31:0]; end
          default:     begin cl_r <= cx_o[31:0]; sl_r <= cy_o[31:0]; end
        endcase
      end
      OP_MUL: begin
        if (!cmd.iter[0]) begin
          prod_r <= opa * opb;
        end else begin
          unique case (mk)
            4'd0: p_r  <= qres;
            4'd1: t1_r <= qres;
            4'd2: t2_r <= qres;
            4'd3: t3_r <= qres;
            4'd4: t4_r <= qres;
            4'd5: t5_r <= qres;
            4'd6: t6_r <= qres;
            4'd7: pp_r <= prod_r[63:0];
            default: qq_r <= prod_r[63:0];
          endcase
        end
      end
      OP_SQ_INIT: begin
        n_r   <= pp_r + qq_r;
        r_r   <= '0;
        bit_r <= 64'h4000_0000_0000_0000;
      end
      OP_SQ_STEP: begin
        if (n_r >= rb) begin
          n_r <= n_r - rb;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      OP_VEC_INIT: begin
        if (xv < 0) begin
          vx_r <= {2'b0, r_r[31:0]};
          vy_r <= -{xv[32], xv};
          vz_r <= DEG_QTR;
        end else begin
          vx_r <= {xv[32], xv};
          vy_r <= {2'b0, r_r[31:0]};
          vz_r <= '0;
        end
      end
      OP_VEC_STEP: begin
        if (vy_r >= 0) begin
          vx_r <= vx_r + vsy;
          vy_r <= vy_r - vsx;
          vz_r <= vz_r + atan_v;
        end else begin
          vx_r <= vx_r - vsy;
          vy_r <= vy_r + vsx;
          vz_r <= vz_r - atan_v;
        end
      end
      OP_FINISH: dprod_r <= 46'(th) * KM_SCALE;
      OP_SET_PEND: pend_r <= cmd.row + 1'b1;
      OP_PUSH_MID: begin
        odata_r <= {pend_r + 1'b1, new_row, pend_r};
        ouser_r <= 2'b01;
        olast_r <= 1'b0;
        pend_r  <= cmd.row + 1'b1;
      end
      OP_PUSH_LAST: begin
        if (cmd.pend_v) begin
          odata_r <= {pend_r + 1'b1, new_row, pend_r};
          ouser_r <= 2'b01;
        end else begin
          odata_r <= {ROW_FW'(0), new_row, ROW_FW'(0)};
          ouser_r <= 2'b00;
        end
        olast_r <= 1'b1;
      end
      OP_PUSH_FULL: begin
        odata_r <= '0;
        ouser_r <= 2'b10;
        olast_r <= 1'b1;
      end
      default: ;
    endcase
  end

  assign sts.cnt      = ROW_FW'(cnt_r);
  assign sts.pair_ok  = (rd_r.src != new_r.src) && (day_abs <= {17'b0, tw_r});
  assign sts.hit      = (dprod_r + KM_ROUND) < thr_r;
  assign sts.out_free = !ov_r || out_tready;

  assign out_tvalid = ov_r;
  assign out_tdata  = {3'b0, odata_r};
  assign out_tuser  = ouser_r;
  assign out_tlast  = olast_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ROWS)) else $error("row count above store size");
  a_full_no_pair: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> !(ouser_r[1] && ouser_r[0])) else $error("refused add reports a pair");
  a_cohort: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && ouser_r[0] |-> odata_r[20:14] == odata_r[6:0] + 1'b1)
    else $error("cohort does not follow first row");
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> cnt_r == '0 && !ov_r) else $error("reset left state behind");
`endif

endmodule

// ===== sv/spatiotemporal_proximity_join.sv =====
// ----------------------------------------------------------------------------
// spatiotemporal_proximity_join
// Joins each added record with all stored records by source, date and distance.
// ----------------------------------------------------------------------------
// Items arrive on the in_ stream; in_tuser set clears the store, otherwise the
// item is added as the next row and compared with every earlier row. Results
// leave on the out_ stream, one per matching pair with out_tlast on the final
// one, or a single no-match or store-full result. The cfg_ port writes the
// time window (index 0) and the distance limit (index 1); the user must write
// them only while idle, which the block does not enforce. A clear gives no
// result. A refused add gives its store-full result once the output register
// is free. The time for each row that passes the source and day tests is set
// by the shared CORDIC unit, the single multiplier and the one-bit-per-cycle
// square root. Reset empties the store and zeroes both registers. When the
// receiver stalls, the result register holds and the walk waits at the next
// result it must deliver; a finished result may wait while the next item is
// taken.
// ----------------------------------------------------------------------------
module spatiotemporal_proximity_join #(
  parameter int MAX_ROWS     = 64,
  parameter int CORDIC_STEPS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [22:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // source_id, day_number, latitude, longitude
  input  logic [0:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // first_row, second_row, cohort
  output logic [1:0]  out_tuser,  // match, store_full
  output logic        out_tlast
);
  import spj_pkg::*;

  spj_cmd_t cmd;
  spj_sts_t sts;

  spj_ctrl #(
    .MAX_ROWS     (MAX_ROWS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_clear  (in_tuser[0]),
    .sts       (sts),
    .cmd       (cmd)
  );

  spj_dp #(
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_row     ({in_tdata[7:0], in_tdata[39:8], in_tdata[63:40], in_tdata[88:64]}),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
